>>> hw/rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes for the two-class ticket queue
// Command, status and sequencer codes, plus the control and status bundles
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_NORMAL = 2'd0,
    CMD_PUSH_PRIO   = 2'd1,
    CMD_SERVE       = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2
  } state_t;

  typedef struct packed {
    logic latch_in;  // capture command and client on a transfer
    logic exec;      // update pointers, counters, stores
    logic load_rd;   // build result from store read data
  } ctrl_t;

  typedef struct packed {
    logic need_read; // serve hit: result waits on the store read
  } dp_sts_t;

  localparam int TICKET_W = 16;
  localparam int CLIENT_W = 16;
  localparam int WAIT_W   = 5;
  localparam int WORD_W   = TICKET_W + CLIENT_W;

endpackage

>>> hw/rtl/two_class_priority_ticket_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue_unit: two-class ticket queue
// Push-normal, push-priority and serve commands over two bounded FIFOs that
// share DEPTH entries; priority entries are served first.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot stall, so capture it on that cycle. Pushes and refused serves give
// their result strobe straight from the execute state; a served entry passes
// a further state, the registered read of the store at the head pointer. busy
// drops as the result is produced, so a new command may transfer while the
// previous result is on the ports. Every push draws a ticket (also a refused
// one), starting at 1 and wrapping at 65536.
// ----------------------------------------------------------------------------
module two_class_priority_ticket_queue_unit #(
  parameter int DEPTH = 16  // total entries over both classes, 2..1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [tcpq_pkg::CLIENT_W-1:0] in_client_id,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [tcpq_pkg::TICKET_W-1:0] out_ticket,
  output logic [tcpq_pkg::CLIENT_W-1:0] out_served_client,
  output logic                          out_served_priority,
  output logic [tcpq_pkg::WAIT_W-1:0]   out_waiting
);
  import tcpq_pkg::*;

  ctrl_t   ctl;
  dp_sts_t sts;

  // sequencer: idle -> execute -> (store read) -> idle
  tcpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // rings, counters, ticket counter and result registers
  tcpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_command          (in_command),
    .in_client_id        (in_client_id),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_ticket          (out_ticket),
    .out_served_client   (out_served_client),
    .out_served_priority (out_served_priority),
    .out_waiting         (out_waiting)
  );

endmodule

>>> hw/rtl/tcpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_ctrl: command sequencer
// Walks each command through execute and, for a served entry, a store read.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcpq_pkg::dp_sts_t sts,
  output tcpq_pkg::ctrl_t   ctl
);
  import tcpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    busy        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.need_read ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        ctl.load_rd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/tcpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_dp: queue datapath
// Two ring stores with head/tail/count, ticket counter and result registers.
// ----------------------------------------------------------------------------
module tcpq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcpq_pkg::ctrl_t               ctl,
  output tcpq_pkg::dp_sts_t             sts,
  input  logic [1:0]                    in_command,
  input  logic [tcpq_pkg::CLIENT_W-1:0] in_client_id,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [tcpq_pkg::TICKET_W-1:0] out_ticket,
  output logic [tcpq_pkg::CLIENT_W-1:0] out_served_client,
  output logic                          out_served_priority,
  output logic [tcpq_pkg::WAIT_W-1:0]   out_waiting
);
  import tcpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > WAIT_W) ? CW : WAIT_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WORD_W-1:0] p_mem [DEPTH];
  logic [WORD_W-1:0] n_mem [DEPTH];
  logic [WORD_W-1:0] p_rd_r, n_rd_r;

  logic [1:0]          cmd_r;
  logic [CLIENT_W-1:0] client_r;
  logic [AW-1:0]       p_head_r, p_head_nxt, p_tail_r, p_tail_nxt;
  logic [AW-1:0]       n_head_r, n_head_nxt, n_tail_r, n_tail_nxt;
  logic [CW-1:0]       p_cnt_r, p_cnt_nxt, n_cnt_r, n_cnt_nxt;
  logic [TICKET_W-1:0] ticket_r, ticket_nxt;
  logic                sel_prio_r, sel_prio_nxt;
  logic                p_we, n_we;
  logic [CW-1:0]       occ;
  logic [WW-1:0]       occ_nxt;

  logic                valid_r, valid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [TICKET_W-1:0] oticket_r, oticket_nxt;
  logic [CLIENT_W-1:0] oclient_r, oclient_nxt;
  logic                oprio_r, oprio_nxt;
  logic [WAIT_W-1:0]   owait_r, owait_nxt;
  logic [WORD_W-1:0]   rd_word;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
    return (idx == LAST) ? '0 : idx + AW'(1);
  endfunction

  assign occ     = p_cnt_r + n_cnt_r;
  assign occ_nxt = WW'(p_cnt_nxt) + WW'(n_cnt_nxt);
  assign rd_word = sel_prio_r ? p_rd_r : n_rd_r;

  assign sts.need_read = (cmd_r == CMD_SERVE) && (occ != '0);

  always_comb begin
    p_head_nxt   = p_head_r;
    p_tail_nxt   = p_tail_r;
    p_cnt_nxt    = p_cnt_r;
    n_head_nxt   = n_head_r;
    n_tail_nxt   = n_tail_r;
    n_cnt_nxt    = n_cnt_r;
    ticket_nxt   = ticket_r;
    sel_prio_nxt = sel_prio_r;
    p_we         = 1'b0;
    n_we         = 1'b0;
    valid_nxt    = 1'b0;
    status_nxt   = status_r;
    oticket_nxt  = oticket_r;
    oclient_nxt  = oclient_r;
    oprio_nxt    = oprio_r;
    owait_nxt    = owait_r;
    if (ctl.exec) begin
      status_nxt  = STS_DONE;
      oticket_nxt = '0;
      oclient_nxt = '0;
      oprio_nxt   = 1'b0;
      case (cmd_r)
        CMD_PUSH_NORMAL, CMD_PUSH_PRIO: begin
          ticket_nxt  = ticket_r + TICKET_W'(1);
          oticket_nxt = ticket_r;
          if (occ >= FULL) begin
            status_nxt = STS_FULL;
          end else if (cmd_r == CMD_PUSH_PRIO) begin
            p_we       = 1'b1;
            p_tail_nxt = ring_inc(p_tail_r);
            p_cnt_nxt  = p_cnt_r + CW'(1);
          end else begin
            n_we       = 1'b1;
            n_tail_nxt = ring_inc(n_tail_r);
            n_cnt_nxt  = n_cnt_r + CW'(1);
          end
        end
        CMD_SERVE: begin
          if (p_cnt_r != '0) begin
            sel_prio_nxt = 1'b1;
            p_head_nxt   = ring_inc(p_head_r);
            p_cnt_nxt    = p_cnt_r - CW'(1);
          end else if (n_cnt_r != '0) begin
            sel_prio_nxt = 1'b0;
            n_head_nxt   = ring_inc(n_head_r);
            n_cnt_nxt    = n_cnt_r - CW'(1);
          end else begin
            status_nxt = STS_EMPTY;
          end
        end
        default: begin
        end
      endcase
      // served entry reports after the store read
      valid_nxt = !sts.need_read;
      owait_nxt = occ_nxt[WAIT_W-1:0];
    end
    if (ctl.load_rd) begin
      valid_nxt   = 1'b1;
      status_nxt  = STS_DONE;
      oticket_nxt = rd_word[WORD_W-1 -: TICKET_W];
      oclient_nxt = rd_word[CLIENT_W-1:0];
      oprio_nxt   = sel_prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_head_r <= '0;
      p_tail_r <= '0;
      p_cnt_r  <= '0;
      n_head_r <= '0;
      n_tail_r <= '0;
      n_cnt_r  <= '0;
      ticket_r <= TICKET_W'(1);
      valid_r  <= 1'b0;
    end else begin
      p_head_r <= p_head_nxt;
      p_tail_r <= p_tail_nxt;
      p_cnt_r  <= p_cnt_nxt;
      n_head_r <= n_head_nxt;
      n_tail_r <= n_tail_nxt;
      n_cnt_r  <= n_cnt_nxt;
      ticket_r <= ticket_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r    <= in_command;
      client_r <= in_client_id;
    end
    sel_prio_r <= sel_prio_nxt;
    status_r   <= status_nxt;
    oticket_r  <= oticket_nxt;
    oclient_r  <= oclient_nxt;
    oprio_r    <= oprio_nxt;
    owait_r    <= owait_nxt;
  end

  // stores: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_tail_r] <= {ticket_r, client_r};
    end
    p_rd_r <= p_mem[p_head_r];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      n_mem[n_tail_r] <= {ticket_r, client_r};
    end
    n_rd_r <= n_mem[n_head_r];
  end

  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_ticket          = oticket_r;
  assign out_served_client   = oclient_r;
  assign out_served_priority = oprio_r;
  assign out_waiting         = owait_r;

endmodule
